// ----- design/fnms_pkg.sv -----
// shared constants, register codes and helper functions for the file name match scorer
`timescale 1ns / 1ps
`default_nettype none
package fnms_pkg;

  // default sizing handed to the top level parameters
  localparam int MAX_NEEDLE_DEF  = 16;
  localparam int LENGTH_BITS_DEF = 16;

  // fixed field widths
  localparam int CHAR_W        = 16;
  localparam int SCORE_W       = 19;
  localparam int START_W       = 16;
  localparam int CFG_LEN_W     = 5;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int NEEDLE_REGS   = 4;
  localparam int CHARS_PER_REG = CFG_DATA_W / CHAR_W;
  localparam int NEEDLE_CHARS  = NEEDLE_REGS * CHARS_PER_REG;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_NEEDLE_LENGTH = 3'd0;
  localparam cfg_idx_t REG_CHARS_0_3     = 3'd1;
  localparam cfg_idx_t REG_CHARS_4_7     = 3'd2;
  localparam cfg_idx_t REG_CHARS_8_11    = 3'd3;
  localparam cfg_idx_t REG_CHARS_12_15   = 3'd4;

  // score terms in thousandths
  localparam int SCORE_BASE  = 1000;
  localparam int BONUS_EXACT = 6000;
  localparam int BONUS_START = 4000;
  localparam int BONUS_SEP   = 2500;
  localparam int RATIO_SCALE = 3000;

  // character codes
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 16'h0041;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 16'h005A;
  localparam logic [CHAR_W-1:0] CH_CASE    = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_DASH    = 16'h002D;
  localparam logic [CHAR_W-1:0] CH_UNDER   = 16'h005F;
  localparam logic [CHAR_W-1:0] CH_DOT     = 16'h002E;

  // fold A-Z to a-z, everything else unchanged
  function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CH_CASE;
    end
    return c;
  endfunction

  // word separators that earn the separator bonus
  function automatic logic is_sep(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_DASH) || (c == CH_UNDER) || (c == CH_DOT);
  endfunction

endpackage
`default_nettype wire

// ----- design/fnms_if.sv -----
// stream interfaces for name characters in and scores out
`timescale 1ns / 1ps
`default_nettype none
interface fnms_in_if;
  logic                         valid;
  logic                         ready;
  logic [fnms_pkg::CHAR_W-1:0]  name_char;
  logic                         last_char;

  modport source (output valid, name_char, last_char, input ready);
  modport sink   (input valid, name_char, last_char, output ready);
endinterface

interface fnms_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fnms_pkg::SCORE_W-1:0] score;
  logic                                matched;
  logic [fnms_pkg::START_W-1:0]        match_start;

  modport source (output valid, score, matched, match_start, input ready);
  modport sink   (input valid, score, matched, match_start, output ready);
endinterface
`default_nettype wire

// ----- design/fnms_front.sv -----
// front end: config registers, character window, match search, per-name record
`timescale 1ns / 1ps
`default_nettype none
module fnms_front #(
  parameter int  MAX_NEEDLE  = fnms_pkg::MAX_NEEDLE_DEF,
  parameter int  LENGTH_BITS = fnms_pkg::LENGTH_BITS_DEF,
  localparam int LEN_W       = $clog2(MAX_NEEDLE + 1),
  localparam int REC_W       = 2 * LENGTH_BITS + LEN_W + 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire fnms_pkg::cfg_idx_t              cfg_index,
  input  wire logic [fnms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  fnms_in_if.sink                              in_if,
  output logic                                 push,
  output logic [REC_W-1:0]                     rec,
  input  wire logic                            full
);

  localparam int CW = fnms_pkg::CHAR_W;
  localparam int NK = (MAX_NEEDLE < fnms_pkg::NEEDLE_CHARS) ? MAX_NEEDLE
                                                            : fnms_pkg::NEEDLE_CHARS;

  typedef struct packed {
    logic                   matched;
    logic [LENGTH_BITS-1:0] n;
    logic [LEN_W-1:0]       len;
    logic [LENGTH_BITS-1:0] start;
    logic                   sep;
  } rec_t;

  logic [fnms_pkg::CFG_LEN_W-1:0]                      len_cfg_r;
  logic [fnms_pkg::CFG_DATA_W-1:0]                     needle_r [fnms_pkg::NEEDLE_REGS];
  logic [fnms_pkg::NEEDLE_REGS*fnms_pkg::CFG_DATA_W-1:0] needle_flat;
  logic [LEN_W-1:0]       len;
  logic [LENGTH_BITS-1:0] len_ext;
  logic [CW-1:0]          rev [MAX_NEEDLE];
  logic [CW-1:0]          win_r [MAX_NEEDLE];
  logic [CW-1:0]          w [MAX_NEEDLE + 1];
  logic [CW-1:0]          sep_char;
  logic                   hit;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_inc;
  logic                   seen_r, sep_r;
  logic [LENGTH_BITS-1:0] start_r, start_new;
  logic                   new_hit, seen_now, sep_now;
  logic [LENGTH_BITS-1:0] start_now;
  logic                   accept;
  rec_t                   rec_w;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= '0;
      for (int r = 0; r < fnms_pkg::NEEDLE_REGS; r++) needle_r[r] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fnms_pkg::REG_NEEDLE_LENGTH: len_cfg_r   <= cfg_wdata[fnms_pkg::CFG_LEN_W-1:0];
        fnms_pkg::REG_CHARS_0_3:     needle_r[0] <= cfg_wdata;
        fnms_pkg::REG_CHARS_4_7:     needle_r[1] <= cfg_wdata;
        fnms_pkg::REG_CHARS_8_11:    needle_r[2] <= cfg_wdata;
        fnms_pkg::REG_CHARS_12_15:   needle_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // active needle length, clamped to the window
  assign len = (len_cfg_r > fnms_pkg::CFG_LEN_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE)
                                                               : LEN_W'(len_cfg_r);
  assign len_ext = LENGTH_BITS'(len);

  always_comb begin
    for (int r = 0; r < fnms_pkg::NEEDLE_REGS; r++) begin
      needle_flat[r*fnms_pkg::CFG_DATA_W +: fnms_pkg::CFG_DATA_W] = needle_r[r];
    end
  end

  // needle reversed so that window entry i lines up with rev[i]
  always_comb begin
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      rev[i] = '0;
      for (int k = 0; k < NK; k++) begin
        if (int'(len) - 1 - i == k) rev[i] = needle_flat[CW*k +: CW];
      end
    end
  end

  // window view after this item shifts in (folded, newest at entry 0)
  always_comb begin
    w[0] = fnms_pkg::fold_lower(in_if.name_char);
    for (int i = 1; i <= MAX_NEEDLE; i++) w[i] = win_r[i-1];
  end

  // compare all live window positions at once
  always_comb begin
    hit = (len != '0);
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      if (i < int'(len) && w[i] != rev[i]) hit = 1'b0;
    end
  end

  // character just before the candidate match
  always_comb begin
    sep_char = '0;
    for (int i = 0; i <= MAX_NEEDLE; i++) begin
      if (i == int'(len)) sep_char = w[i];
    end
  end

  // saturating name length
  assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;

  assign new_hit   = !seen_r && hit && (cnt_inc >= len_ext);
  assign start_new = cnt_inc - len_ext;
  assign seen_now  = seen_r | new_hit;
  assign start_now = new_hit ? start_new : start_r;
  assign sep_now   = new_hit ? ((start_new != '0) && fnms_pkg::is_sep(sep_char)) : sep_r;

  assign in_if.ready = !full;
  assign accept      = in_if.valid && in_if.ready;
  assign push        = accept && in_if.last_char;

  // per-name record for the back end
  always_comb begin
    rec_w.matched = seen_now && (len != '0);
    rec_w.n       = cnt_inc;
    rec_w.len     = len;
    rec_w.start   = start_now;
    rec_w.sep     = sep_now;
  end
  assign rec = rec_w;

  // window shift; entries past the count are never compared, so no clearing
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_NEEDLE; i++) win_r[i] <= w[i];
    end
  end

  // per-name state, cleared after the last character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      seen_r  <= 1'b0;
      start_r <= '0;
      sep_r   <= 1'b0;
    end else if (accept) begin
      if (in_if.last_char) begin
        cnt_r   <= '0;
        seen_r  <= 1'b0;
        start_r <= '0;
        sep_r   <= 1'b0;
      end else begin
        cnt_r   <= cnt_inc;
        seen_r  <= seen_now;
        start_r <= start_now;
        sep_r   <= sep_now;
      end
    end
  end

  // a finished name leaves no state behind
  a_name_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (cnt_r == '0) && !seen_r)
    else $error("per-name state not cleared after last character");

endmodule
`default_nettype wire

// ----- design/fnms_fifo.sv -----
// short register queue of per-name records between front and back
`timescale 1ns / 1ps
`default_nettype none
module fnms_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  localparam int DEPTH = fnms_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");

endmodule
`default_nettype wire

// ----- design/fnms_back.sv -----
// back end: length ratio divider, score assembly and output register
`timescale 1ns / 1ps
`default_nettype none
module fnms_back #(
  parameter int  MAX_NEEDLE  = fnms_pkg::MAX_NEEDLE_DEF,
  parameter int  LENGTH_BITS = fnms_pkg::LENGTH_BITS_DEF,
  localparam int LEN_W       = $clog2(MAX_NEEDLE + 1),
  localparam int REC_W       = 2 * LENGTH_BITS + LEN_W + 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [REC_W-1:0] rec,
  input  wire logic             empty,
  output logic                  pop,
  fnms_out_if.source            out_if
);

  localparam int SW    = fnms_pkg::SCORE_W;
  localparam int NUM_W = $clog2(fnms_pkg::RATIO_SCALE * MAX_NEEDLE + 1);
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  typedef struct packed {
    logic                   matched;
    logic [LENGTH_BITS-1:0] n;
    logic [LEN_W-1:0]       len;
    logic [LENGTH_BITS-1:0] start;
    logic                   sep;
  } rec_t;

  rec_t                   rec_in, rec_r;
  logic [1:0]             state_r, state_nxt;
  logic [NUM_W-1:0]       num_r, quo_r;
  logic [LENGTH_BITS:0]   rem_r, rem_sh, rem_nxt;
  logic                   qbit;
  logic [CNT_W-1:0]       cnt_r;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [SW-1:0]   score_r;
  logic                   matched_r;
  logic [fnms_pkg::START_W-1:0] start_r;
  logic [SW-1:0]          bonus, score_calc;
  logic                   load_out;

  assign rec_in = rec;
  assign pop    = (state_r == ST_IDLE) && !empty;

  // one restoring division step per cycle
  assign rem_sh  = {rem_r[LENGTH_BITS-1:0], num_r[NUM_W-1]};
  assign qbit    = (rem_sh >= {1'b0, rec_r.n});
  assign rem_nxt = qbit ? rem_sh - {1'b0, rec_r.n} : rem_sh;

  // bonus: exact length, then start of name, then after a separator
  always_comb begin
    priority if (rec_r.n == LENGTH_BITS'(rec_r.len)) bonus = SW'(fnms_pkg::BONUS_EXACT);
    else if (rec_r.start == '0)                       bonus = SW'(fnms_pkg::BONUS_START);
    else if (rec_r.sep)                               bonus = SW'(fnms_pkg::BONUS_SEP);
    else                                              bonus = '0;
  end

  // score modulo the output width; 4 per character is a shift
  assign score_calc = SW'(fnms_pkg::SCORE_BASE) + bonus + SW'(quo_r)
                    - SW'({rec_r.n, 2'b00});

  assign load_out = (state_r == ST_FIN) && (!out_valid_r || out_if.ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (pop) state_nxt = rec_in.matched ? ST_DIV : ST_FIN;
      ST_DIV:  if (cnt_r == CNT_W'(NUM_W - 1)) state_nxt = ST_FIN;
      ST_FIN:  if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (load_out) out_valid_nxt = 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (pop)                    cnt_r <= '0;
      else if (state_r == ST_DIV) cnt_r <= cnt_r + 1'b1;
    end
  end

  // record, divider datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r <= rec_in;
      num_r <= NUM_W'(fnms_pkg::RATIO_SCALE * int'(rec_in.len));
      rem_r <= '0;
      quo_r <= '0;
    end else if (state_r == ST_DIV) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], qbit};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      matched_r <= rec_r.matched;
      score_r   <= rec_r.matched ? $signed(score_calc) : '0;
      start_r   <= rec_r.matched ? fnms_pkg::START_W'(rec_r.start) : '0;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.score       = score_r;
  assign out_if.matched     = matched_r;
  assign out_if.match_start = start_r;

  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !matched_r |-> (score_r == '0) && (start_r == '0))
    else $error("unmatched result with nonzero score or start");
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= CNT_W'(NUM_W - 1)))
    else $error("divider ran past its last step");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == ST_DIV) || (state_r == ST_FIN))
    else $error("record taken without starting work");

endmodule
`default_nettype wire

// ----- design/file_name_match_scorer.sv -----
// File name match scorer: streams name characters, scores the first needle occurrence.
//
// Channels: in_if carries one 16-bit name character per item with last_char
// marking the final character; out_if gives one item per name (score,
// matched, match_start). Needle length and characters are loaded through the
// cfg write port; the user must do so only while no name is in flight, and
// the block does not enforce it. The front end takes one character per cycle
// while the queue is not full, comparing the needle with a folded character
// window as each is accepted. On the last character a per-name record enters
// a two-entry queue. The back end's restoring divider gives floor(3000*L/n),
// one quotient bit per cycle over a clog2(3000*MAX_NEEDLE+1)-bit dividend.
// A matched name passes through the idle, divide and finish states, then its
// result is loaded into the output register. Unmatched names skip the divider.
// Names shorter than the back-end time per name can fill the queue, and then
// in_if.ready drops until a record is taken.
// Reset clears the needle registers, per-name state, the queue and the
// output valid flag. When the receiver stalls, the result holds in the output
// register, the back end waits, and the queue then the front end back up.
`timescale 1ns / 1ps
`default_nettype none
module file_name_match_scorer #(
  parameter int MAX_NEEDLE  = fnms_pkg::MAX_NEEDLE_DEF,
  parameter int LENGTH_BITS = fnms_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire fnms_pkg::cfg_idx_t              cfg_index,
  input  wire logic [fnms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  fnms_in_if.sink                              in_if,
  fnms_out_if.source                           out_if
);

  localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
  localparam int REC_W = 2 * LENGTH_BITS + LEN_W + 2;

  logic             push, pop, full, empty;
  logic [REC_W-1:0] rec_push, rec_pop;

  // character window and match search
  fnms_front #(
    .MAX_NEEDLE  (MAX_NEEDLE),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .push      (push),
    .rec       (rec_push),
    .full      (full)
  );

  // per-name records
  fnms_fifo #(
    .W (REC_W)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (rec_push),
    .full  (full),
    .pop   (pop),
    .rdata (rec_pop),
    .empty (empty)
  );

  // divider and score
  fnms_back #(
    .MAX_NEEDLE  (MAX_NEEDLE),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .rec    (rec_pop),
    .empty  (empty),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule
`default_nettype wire

// ----- tb/tb_file_name_match_scorer.sv -----
// testbench for the file name match scorer: streams names and checks every score
`timescale 1ns / 1ps
module tb_file_name_match_scorer;
  import fnms_pkg::*;

  localparam int RANDOM_ITEMS   = 1200;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 40;
  localparam int CHAR_PENALTY   = 4;
  localparam int WINDOW_DEPTH   = MAX_NEEDLE_DEF + 1;
  localparam int COUNT_CEIL     = (1 << LENGTH_BITS_DEF) - 1;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } name_item_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      matched;
    logic [START_W-1:0]        start;
  } score_rec_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fnms_in_if  name_in ();
  fnms_out_if score_out ();

  file_name_match_scorer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (name_in),
    .out_if    (score_out)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // needle registers as the block should hold them
  logic [CFG_LEN_W-1:0]  needle_len_reg;
  logic [CFG_DATA_W-1:0] needle_reg [NEEDLE_REGS];

  // per-name scoring state
  logic [CHAR_W-1:0] char_win [WINDOW_DEPTH];
  int                name_count;
  bit                match_hit;
  int                match_pos;
  bit                sep_before;

  name_item_t pending_chars [$];
  score_rec_t expected_scores [$];

  bit src_gaps_on;
  bit sink_stalls_on;
  int error_count;
  int names_scored;
  int names_matched;
  int settings_loaded;
  int random_chars;

  function automatic int needle_span();
    return (needle_len_reg > MAX_NEEDLE_DEF) ? MAX_NEEDLE_DEF : int'(needle_len_reg);
  endfunction

  function automatic logic [CHAR_W-1:0] needle_at(input int k);
    if (k >= NEEDLE_CHARS) begin
      return '0;
    end
    return needle_reg[k / CHARS_PER_REG][CHAR_W * (k % CHARS_PER_REG) +: CHAR_W];
  endfunction

  function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CH_CASE : c;
  endfunction

  function automatic bit is_word_break(input logic [CHAR_W-1:0] c);
    return c == CH_SPACE || c == CH_DASH || c == CH_UNDER || c == CH_DOT;
  endfunction

  task automatic clear_name_state();
    foreach (char_win[i]) char_win[i] = '0;
    name_count = 0;
    match_hit  = 1'b0;
    match_pos  = 0;
    sep_before = 1'b0;
  endtask

  // advance the window by one character, score the name on its last one
  task automatic score_name_char(input logic [CHAR_W-1:0] c, input logic last);
    int         len;
    int         s;
    bit         hit;
    score_rec_t rec;
    len = needle_span();
    for (int i = WINDOW_DEPTH - 1; i > 0; i--) char_win[i] = char_win[i-1];
    char_win[0] = c;
    if (name_count < COUNT_CEIL) name_count++;

    // first occurrence only
    if (!match_hit && len > 0 && name_count >= len) begin
      hit = 1'b1;
      for (int j = 0; j < len; j++) begin
        if (to_lower(char_win[len-1-j]) != needle_at(j)) hit = 1'b0;
      end
      if (hit) begin
        match_hit  = 1'b1;
        match_pos  = name_count - len;
        sep_before = match_pos > 0 && is_word_break(char_win[len]);
      end
    end

    if (last) begin
      rec = '0;
      if (match_hit && len > 0) begin
        s = SCORE_BASE;
        if (name_count == len) s += BONUS_EXACT;
        else if (match_pos == 0) s += BONUS_START;
        else if (sep_before) s += BONUS_SEP;
        s += (RATIO_SCALE * len) / name_count;
        s -= CHAR_PENALTY * name_count;
        rec.score   = s[SCORE_W-1:0];
        rec.matched = 1'b1;
        rec.start   = match_pos[START_W-1:0];
      end
      expected_scores.insert(expected_scores.size(), rec);
      clear_name_state();
    end
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, msg);
  endtask

  // input driver
  int         gap_left;
  name_item_t next_item;
  always @(posedge clk) begin
    if (!rst_n) begin
      name_in.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (name_in.valid && name_in.ready) begin
        score_name_char(name_in.name_char, name_in.last_char);
      end
      if (!name_in.valid || name_in.ready) begin
        if (gap_left > 0 || pending_chars.size() == 0) begin
          if (gap_left > 0) gap_left--;
          name_in.valid <= 1'b0;
        end else begin
          next_item = pending_chars.pop_front();
          name_in.name_char <= next_item.ch;
          name_in.last_char <= next_item.last;
          name_in.valid     <= 1'b1;
          gap_left = src_gaps_on ? $urandom_range(0, 3) : 0;
        end
      end
    end
  end

  // result monitor and checker
  int         stall_left;
  score_rec_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      score_out.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (score_out.valid && score_out.ready) begin
        names_scored++;
        if (score_out.matched) names_matched++;
        if (expected_scores.size() == 0) begin
          report_mismatch($sformatf("result with no name pending: score %0d matched %0b",
                                    score_out.score, score_out.matched));
        end else begin
          want = expected_scores.pop_front();
          if (score_out.score !== want.score)
            report_mismatch($sformatf("score %0d, want %0d", score_out.score, want.score));
          if (score_out.matched !== want.matched)
            report_mismatch($sformatf("matched %0b, want %0b", score_out.matched, want.matched));
          if (score_out.match_start !== want.start)
            report_mismatch($sformatf("match_start %0d, want %0d",
                                      score_out.match_start, want.start));
        end
        stall_left = sink_stalls_on ? $urandom_range(0, 3) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        score_out.ready <= 1'b0;
      end else begin
        score_out.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (name_in.valid && name_in.ready) || (score_out.valid && score_out.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_scores.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_char(input logic [CHAR_W-1:0] c, input logic last);
    name_item_t it;
    it.ch   = c;
    it.last = last;
    pending_chars.insert(pending_chars.size(), it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(CHAR_W'(s[i]), i == s.len() - 1);
  endtask

  function automatic logic [CHAR_W-1:0] rand_sep();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_DASH;
      2: return CH_UNDER;
      default: return CH_DOT;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] rand_digit();
    return 16'h0030 + CHAR_W'($urandom_range(0, 9));
  endfunction

  // filler characters for names, with the fold boundaries thrown in
  function automatic logic [CHAR_W-1:0] rand_text_char();
    case ($urandom_range(0, 9))
      0: return CHAR_W'($urandom_range(0, 16'hFFFF));
      1: begin
        case ($urandom_range(0, 5))
          0: return 16'h0040;
          1: return 16'h005B;
          2: return 16'h0060;
          3: return 16'h007B;
          4: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      2: return rand_sep();
      3: return rand_digit();
      4, 5: return CH_UPPER_A + CHAR_W'($urandom_range(0, 25));
      default: return 16'h0061 + CHAR_W'($urandom_range(0, 25));
    endcase
  endfunction

  // needle characters: mostly lower case, some that can never match
  function automatic logic [CHAR_W-1:0] rand_needle_char();
    case ($urandom_range(0, 15))
      0: return CHAR_W'($urandom_range(0, 16'hFFFF));
      1: return rand_digit();
      2: return rand_sep();
      3: return CH_UPPER_A + CHAR_W'($urandom_range(0, 25));
      default: return 16'h0061 + CHAR_W'($urandom_range(0, 25));
    endcase
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_NEEDLE_LENGTH: needle_len_reg = val[CFG_LEN_W-1:0];
      REG_CHARS_0_3:     needle_reg[0] = val;
      REG_CHARS_4_7:     needle_reg[1] = val;
      REG_CHARS_8_11:    needle_reg[2] = val;
      REG_CHARS_12_15:   needle_reg[3] = val;
      default: ;
    endcase
  endtask

  // load a needle while the block is idle
  task automatic load_needle(input logic [CFG_DATA_W-1:0] len_word,
                             input logic [CFG_DATA_W-1:0] w0, input logic [CFG_DATA_W-1:0] w1,
                             input logic [CFG_DATA_W-1:0] w2, input logic [CFG_DATA_W-1:0] w3,
                             input bit poke_unused);
    write_reg(REG_NEEDLE_LENGTH, len_word);
    write_reg(REG_CHARS_0_3, w0);
    write_reg(REG_CHARS_4_7, w1);
    write_reg(REG_CHARS_8_11, w2);
    write_reg(REG_CHARS_12_15, w3);
    if (poke_unused)
      write_reg(cfg_idx_t'(REG_CHARS_12_15 + $urandom_range(1, 3)), {$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // let every expected result arrive, then let the back end settle
  task automatic wait_drain();
    while (pending_chars.size() != 0 || name_in.valid || expected_scores.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one name: mostly the needle in random case among filler, some broken or pure noise
  task automatic push_random_name(output int count);
    logic [CHAR_W-1:0] nm [$];
    logic [CHAR_W-1:0] c;
    int                kind;
    int                len;
    int                pre;
    int                post;
    int                cut;
    kind = $urandom_range(0, 9);
    len  = needle_span();
    if (kind < 2 || len == 0) begin
      repeat ($urandom_range(1, 20)) nm.insert(nm.size(), rand_text_char());
    end else begin
      pre  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      post = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      repeat (pre) nm.insert(nm.size(), rand_text_char());
      if (pre > 0 && $urandom_range(0, 2) == 0) nm[pre-1] = rand_sep();
      cut = (kind == 2) ? $urandom_range(0, len - 1) : len;
      for (int k = 0; k < cut; k++) begin
        c = needle_at(k);
        if (c >= 16'h0061 && c <= 16'h007A && $urandom_range(0, 1) == 1) c = c - CH_CASE;
        nm.insert(nm.size(), c);
      end
      // one character spoiled
      if (kind == 3) nm[pre + $urandom_range(0, len - 1)] = rand_text_char();
      repeat (post) nm.insert(nm.size(), rand_text_char());
    end
    if (nm.size() == 0) nm.insert(nm.size(), rand_text_char());
    foreach (nm[i]) push_char(nm[i], i == nm.size() - 1);
    count = nm.size();
  endtask

  // stimulus
  initial begin
    logic [CFG_DATA_W-1:0] len_word;
    logic [CFG_DATA_W-1:0] regs [NEEDLE_REGS];
    int                    len_pick;
    int                    phase_chars;
    int                    target;
    int                    count;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_NEEDLE_LENGTH;
    cfg_wdata         = '0;
    name_in.valid     = 1'b0;
    name_in.name_char = '0;
    name_in.last_char = 1'b0;
    score_out.ready   = 1'b0;
    needle_len_reg    = '0;
    foreach (needle_reg[i]) needle_reg[i] = '0;
    clear_name_state();
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // empty needle after reset, with the extreme character codes
    push_char(16'h0000, 1'b0);
    push_char(16'hFFFF, 1'b1);
    wait_drain();

    // needle "ab": exact, at start, after each separator, plain middle, too short
    load_needle(64'd2, 64'h0000_0000_0062_0061, '0, '0, '0, 1'b1);
    push_text("AB");
    push_text("abX");
    push_text("x-aB");
    push_text("q ab");
    push_text("r_Ab");
    push_text("s.ab");
    push_text("tab");
    push_text("a");
    wait_drain();

    // random phases, each with its own needle and idle pattern
    while (random_chars < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len_pick = 0;
        1:       len_pick = 1;
        2, 3:    len_pick = MAX_NEEDLE_DEF;
        4:       len_pick = $urandom_range(MAX_NEEDLE_DEF + 1, 31);
        default: len_pick = $urandom_range(2, MAX_NEEDLE_DEF - 1);
      endcase
      len_word = {$urandom, $urandom};
      len_word[CFG_LEN_W-1:0] = len_pick[CFG_LEN_W-1:0];
      case ($urandom_range(0, 9))
        0: foreach (regs[i]) regs[i] = '1;
        1: foreach (regs[i]) regs[i] = '0;
        default: begin
          foreach (regs[i])
            regs[i] = {rand_needle_char(), rand_needle_char(),
                       rand_needle_char(), rand_needle_char()};
        end
      endcase
      load_needle(len_word, regs[0], regs[1], regs[2], regs[3], $urandom_range(0, 3) == 0);
      src_gaps_on    = $urandom_range(0, 3) != 0;
      sink_stalls_on = $urandom_range(0, 3) != 0;
      phase_chars = 0;
      target      = $urandom_range(60, 160);
      while (phase_chars < target) begin
        push_random_name(count);
        phase_chars += count;
      end
      random_chars += phase_chars;
      wait_drain();
    end

    $display("scored %0d names, %0d with a needle hit, %0d random characters",
             names_scored, names_matched, random_chars);
    $display("needle settings loaded: %0d, including empty and clamped lengths",
             settings_loaded);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
